// File: hw/rtl/assert_macros.svh
// assertion macros for the mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// File: hw/rtl/ltdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdm_pkg
// shared constants and types of the layer to device mapper
// ----------------------------------------------------------------------------
package ltdm_pkg;
   localparam int unsigned DEV_MAX = 16;
   localparam logic [1:0] CSR_DEVICES = 2'd0;
   localparam logic [1:0] CSR_LAYERS  = 2'd1;
   localparam logic [1:0] CSR_TLIMIT  = 2'd2;

   // state codes of the query sequencer
   localparam logic [1:0] ST_REBUILD = 2'd0;
   localparam logic [1:0] ST_IDLE    = 2'd1;
   localparam logic [1:0] ST_SCAN    = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   typedef struct packed {
      logic load;   // start of a scan with a new layer/stage query
      logic shift;  // move data one cell on
   } cell_ctl_type;
endpackage

// File: hw/rtl/ltdm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdm_cell
// one pipeline stage range entry; a query token passes through the row
// ----------------------------------------------------------------------------
module ltdm_cell
   import ltdm_pkg::*;
#(
   parameter int LB = 16,
   parameter int SB = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [SB-1:0] cell_idx,
   input  logic          wr_en,
   input  logic [LB-1:0] wr_start,
   input  logic [LB-1:0] wr_end,
   input  logic          active,
   input  cell_ctl_type  ctl,
   input  logic [LB-1:0] layer_prev,
   input  logic          found_prev,
   input  logic [SB-1:0] stage_prev,
   input  logic [SB-1:0] sq_prev,
   input  logic          ok_prev,
   input  logic [LB-1:0] first_prev,
   input  logic [LB-1:0] last_prev,
   output logic [LB-1:0] layer_out,
   output logic          found_out,
   output logic [SB-1:0] stage_out,
   output logic [SB-1:0] sq_out,
   output logic          ok_out,
   output logic [LB-1:0] first_out,
   output logic [LB-1:0] last_out
);
   logic [LB-1:0] start_ff, end_ff;
   logic          hit, qhit;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
      end else if (wr_en) begin
         start_ff <= wr_start;
         end_ff   <= wr_end;
      end
   end

   assign hit  = active && !found_prev && layer_prev >= start_ff && layer_prev <= end_ff;
   assign qhit = active && ok_prev && sq_prev == cell_idx;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         layer_out <= layer_prev;
         found_out <= found_prev | hit;
         stage_out <= hit ? cell_idx : stage_prev;
         sq_out    <= sq_prev;
         ok_out    <= ok_prev;
         first_out <= qhit ? start_ff : first_prev;
         last_out  <= qhit ? end_ff : last_prev;
      end
   end
endmodule

// File: hw/rtl/ltdm_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdm_planner
// derives degree and stage count, then emits one range per cycle
// ----------------------------------------------------------------------------
module ltdm_planner
   import ltdm_pkg::*;
#(
   parameter int LB = 16,
   parameter int SB = 4,
   parameter int NS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [7:0]    devices,
   input  logic [LB-1:0] total,
   input  logic [7:0]    tlimit,
   output logic          busy,
   output logic [4:0]    degree,
   output logic [4:0]    stages,
   output logic [4:0]    dev_count,
   output logic          wr_en,
   output logic [SB-1:0] wr_idx,
   output logic [LB-1:0] wr_start,
   output logic [LB-1:0] wr_end
);
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_DIV   = 2'd1;
   localparam logic [1:0] PH_WRITE = 2'd2;

   logic [4:0]    dc, lim, best, quot;
   logic [4:0]    degree_ff, stages_ff, dc_ff;
   logic [SB:0]   s_ff, s_in;
   logic [1:0]    ph_ff, ph_in;
   logic [LB-1:0] base_ff, base_in, rem_ff, rem_in, cur_ff, cur_in;
   logic [LB-1:0] span;

   // largest degree within the limit whose cofactor gives the device count
   always_comb begin
      dc = (devices == 8'd0) ? 5'd1 : (devices > 8'd16) ? 5'd16 : devices[4:0];
      lim = (tlimit == 8'd0) ? 5'd1 : (tlimit > 8'd16) ? 5'd16 : tlimit[4:0];
      if (lim > dc) lim = dc;
      best = 5'd1;
      quot = 5'd1;
      for (int d = 1; d <= 16; d++) begin
         for (int q = 1; q <= 16; q++) begin
            if (d <= int'(lim) && d * q == int'(dc)) begin
               best = 5'(d);
               quot = 5'(q);
            end
         end
      end
   end

   // phase 1: divide by repeated subtraction, one stage count per cycle
   assign span = base_ff + ((LB'(s_ff) < rem_ff) ? LB'(1) : LB'(0));

   always_comb begin
      ph_in = ph_ff; s_in = s_ff; base_in = base_ff; rem_in = rem_ff; cur_in = cur_ff;
      wr_en = 1'b0;
      unique case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               ph_in = PH_DIV; base_in = '0; rem_in = total; s_in = '0; cur_in = '0;
            end
         end
         PH_DIV: begin
            if ({1'b0, rem_ff} >= {{(LB-4){1'b0}}, stages_ff}) begin
               rem_in = rem_ff - LB'(stages_ff);
               base_in = base_ff + LB'(1);
            end else ph_in = PH_WRITE;
         end
         PH_WRITE: begin
            wr_en = 1'b1;
            cur_in = cur_ff + span;
            s_in = s_ff + 1'b1;
            if (s_ff == (SB+1)'(NS - 1) || s_ff + 1'b1 >= (SB+1)'(stages_ff))
               ph_in = PH_IDLE;
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         degree_ff <= 5'd1; stages_ff <= 5'd1; dc_ff <= 5'd1;
      end else begin
         ph_ff <= ph_in;
         if (start && ph_ff == PH_IDLE) begin
            degree_ff <= best;
            stages_ff <= quot;
            dc_ff <= dc;
         end
      end
      s_ff <= s_in; base_ff <= base_in; rem_ff <= rem_in; cur_ff <= cur_in;
   end

   assign busy = (ph_ff != PH_IDLE);
   assign degree = degree_ff;
   assign stages = stages_ff;
   assign dev_count = dc_ff;
   assign wr_idx = s_ff[SB-1:0];
   assign wr_start = (total == '0) ? '0 : cur_ff;
   assign wr_end = (total == '0) ? '0 : (span == '0) ? cur_ff : cur_ff + span - LB'(1);
endmodule

// File: hw/rtl/layer_to_device_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_to_device_mapper
// maps layers and shards of a model onto pipeline stages and devices
// ----------------------------------------------------------------------------
// Usage: write devices_in_use (0), layer_total (1), tensor_limit (2) on the
// csr_ channel; csr_ready is high only while no request is in flight and no
// rebuild runs, and a write to an unknown index is taken and ignored.
// A write starts a plan rebuild on the next cycle: a division by repeated
// subtraction of the stage count from layer_total, then one range written per
// stage into a row of MAX_STAGES cells. After reset the same rebuild runs
// once; requests wait until it is done.
// A request walks the cell row one cell per cycle while restoring dividers
// for the shard width and for the shard index modulo the degree run
// alongside; the response is registered once all three are done, and only
// one request is in the cell row at a time.
// The response sits in an output register until taken; a stalled rsp_ side
// holds it, the next request is still taken and waits in ST_DONE for it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module layer_to_device_mapper
   import ltdm_pkg::*;
#(
   parameter int MAX_STAGES = 16,
   parameter int LAYER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [15:0]           req_layer_index,
   input  logic [15:0]           req_shard_index,
   input  logic [7:0]            req_stage_query,
   input  logic [19:0]           req_hidden_width,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_layer_stage,
   output logic [3:0]            rsp_layer_device,
   output logic [3:0]            rsp_shard_device,
   output logic [19:0]           rsp_shard_width,
   output logic                  rsp_range_ok,
   output logic [15:0]           rsp_range_first,
   output logic [15:0]           rsp_range_last,
   output logic                  rsp_plan_valid,
   output logic [4:0]            rsp_tensor_degree,
   output logic [4:0]            rsp_pipeline_stages
);
   localparam int SB = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int LB = LAYER_BITS;

   logic [7:0]    dev_ff;
   logic [LB-1:0] tot_ff;
   logic [7:0]    tlim_ff;
   logic          rebuild_ff, csr_wr;
   logic          busy;
   logic [4:0]    degree, stages, dev_count;
   logic          pwr;
   logic [SB-1:0] pidx;
   logic [LB-1:0] pstart, pend;

   assign csr_wr = csr_valid && csr_ready &&
      (csr_index == CSR_DEVICES || csr_index == CSR_LAYERS || csr_index == CSR_TLIMIT);

   // the rebuild starts in the cycle after the write so it sees the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= 8'd1; tot_ff <= '0; tlim_ff <= 8'd2; rebuild_ff <= 1'b1;
      end else begin
         rebuild_ff <= csr_wr;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DEVICES: dev_ff <= csr_data[7:0];
               CSR_LAYERS:  tot_ff <= csr_data[LB-1:0];
               CSR_TLIMIT:  tlim_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   ltdm_planner #(.LB(LB), .SB(SB), .NS(MAX_STAGES)) u_plan (
      .clock, .reset, .start(rebuild_ff), .devices(dev_ff), .total(tot_ff),
      .tlimit(tlim_ff), .busy, .degree, .stages, .dev_count,
      .wr_en(pwr), .wr_idx(pidx), .wr_start(pstart), .wr_end(pend));

   // sequencer
   logic [1:0]    st_ff, st_in;
   logic [SB:0]   cnt_ff, cnt_in;
   logic [4:0]    dcnt_ff, dcnt_in;
   logic [15:0]   shard_ff;
   logic [20:0]   rmd_ff, rmd_in;
   logic [19:0]   quo_ff, quo_in, num_ff, num_in;
   logic [4:0]    smod_ff, smod_in;
   logic [4:0]    sbit_ff, sbit_in;
   cell_ctl_type  ctl;

   logic [LB-1:0] layer_c [MAX_STAGES+1];
   logic          found_c [MAX_STAGES+1];
   logic [SB-1:0] stage_c [MAX_STAGES+1];
   logic [SB-1:0] sq_c    [MAX_STAGES+1];
   logic          ok_c    [MAX_STAGES+1];
   logic [LB-1:0] first_c [MAX_STAGES+1];
   logic [LB-1:0] last_c  [MAX_STAGES+1];
   logic [LB-1:0] layer_h;
   logic [SB-1:0] sq_h;
   logic          ok_h;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         layer_h <= LB'(req_layer_index);
         sq_h <= req_stage_query[SB-1:0];
         ok_h <= ({3'd0, req_stage_query} < {6'd0, stages}) &&
                 (32'(req_stage_query) < MAX_STAGES);
         shard_ff <= req_shard_index;
      end
   end

   assign layer_c[0] = layer_h; assign found_c[0] = 1'b0; assign stage_c[0] = '0;
   assign sq_c[0] = sq_h; assign ok_c[0] = ok_h;
   assign first_c[0] = '0; assign last_c[0] = '0;

   for (genvar g = 0; g < MAX_STAGES; g++) begin : g_cell
      logic [SB-1:0] cin_layer_dummy;
      assign cin_layer_dummy = SB'(g);
      ltdm_cell #(.LB(LB), .SB(SB)) u_cell (
         .clock, .reset, .cell_idx(cin_layer_dummy),
         .wr_en(pwr && pidx == SB'(g)), .wr_start(pstart), .wr_end(pend),
         .active(32'(g) < 32'(stages)), .ctl,
         .layer_prev(g == 0 ? layer_h : layer_c[g]), .found_prev(found_c[g]),
         .stage_prev(stage_c[g]), .sq_prev(sq_c[g]), .ok_prev(ok_c[g]),
         .first_prev(first_c[g]), .last_prev(last_c[g]),
         .layer_out(layer_c[g+1]), .found_out(found_c[g+1]), .stage_out(stage_c[g+1]),
         .sq_out(sq_c[g+1]), .ok_out(ok_c[g+1]), .first_out(first_c[g+1]),
         .last_out(last_c[g+1]));
   end

   // restoring division of hidden width and shard index by the degree
   logic [20:0] trial;
   logic [16:0] strial;
   assign trial = {rmd_ff[19:0], num_ff[19]} - {16'd0, degree};
   assign strial = {12'd0, smod_ff[3:0], shard_ff[4'd15 - sbit_ff[3:0]]} - {12'd0, degree};

   assign csr_ready = (st_ff == ST_IDLE) && !busy;
   assign req_ready = (st_ff == ST_IDLE) && !busy && !csr_valid;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; dcnt_in = dcnt_ff;
      rmd_in = rmd_ff; quo_in = quo_ff; num_in = num_ff;
      smod_in = smod_ff; sbit_in = sbit_ff;
      ctl = '0;
      unique case (st_ff)
         ST_REBUILD: if (!busy) st_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.load = 1'b1; st_in = ST_SCAN; cnt_in = '0; dcnt_in = '0;
               rmd_in = '0; quo_in = '0;
               num_in = req_hidden_width;
               smod_in = '0; sbit_in = '0;
            end
         end
         ST_SCAN: begin
            if (32'(cnt_ff) < MAX_STAGES) begin
               ctl.shift = 1'b1; cnt_in = cnt_ff + 1'b1;
            end
            if (dcnt_ff < 5'd20) begin
               dcnt_in = dcnt_ff + 5'd1;
               num_in = num_ff << 1;
               if (!trial[20]) begin
                  rmd_in = trial; quo_in = {quo_ff[18:0], 1'b1};
               end else begin
                  rmd_in = {rmd_ff[19:0], num_ff[19]}; quo_in = {quo_ff[18:0], 1'b0};
               end
            end
            if (sbit_ff < 5'd16) begin
               sbit_in = sbit_ff + 5'd1;
               smod_in = strial[16] ? {smod_ff[3:0], shard_ff[4'd15 - sbit_ff[3:0]]}
                                    : strial[4:0];
            end
            if (32'(cnt_ff) >= MAX_STAGES && dcnt_ff >= 5'd20 && sbit_ff >= 5'd16)
               st_in = ST_DONE;
         end
         ST_DONE: if (!rsp_valid || rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (busy || rebuild_ff || csr_wr) st_in = ST_REBUILD;
   end

   logic [3:0] stg;
   logic [8:0] ldev, sdev;
   logic [LB-1:0] fin_layer;
   assign fin_layer = layer_c[MAX_STAGES];
   always_comb begin
      if (found_c[MAX_STAGES]) stg = 4'(stage_c[MAX_STAGES]);
      else if (tot_ff != '0 && fin_layer >= tot_ff) stg = 4'(stages - 5'd1);
      else stg = 4'd0;
      ldev = 9'(stg) * 9'(degree);
      sdev = ldev + 9'(smod_ff);
      if (ldev >= 9'(dev_count)) ldev = 9'(dev_count) - 9'd1;
      if (sdev >= 9'(dev_count)) sdev = 9'(dev_count) - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_REBUILD; rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
      cnt_ff <= cnt_in; dcnt_ff <= dcnt_in; rmd_ff <= rmd_in; quo_ff <= quo_in;
      num_ff <= num_in; smod_ff <= smod_in; sbit_ff <= sbit_in;
      if (st_ff == ST_DONE && (!rsp_valid || rsp_ready)) begin
         rsp_layer_stage <= stg;
         rsp_layer_device <= ldev[3:0];
         rsp_shard_device <= sdev[3:0];
         // ceiling: round the floor quotient up when a remainder is left
         rsp_shard_width <= quo_ff + {19'd0, (rmd_ff != 21'd0)};
         rsp_range_ok <= ok_c[MAX_STAGES];
         rsp_range_first <= ok_c[MAX_STAGES] ? 16'(first_c[MAX_STAGES]) : 16'd0;
         rsp_range_last <= ok_c[MAX_STAGES] ? 16'(last_c[MAX_STAGES]) : 16'd0;
         rsp_plan_valid <= (tot_ff == '0) || ({16'd0, tot_ff} >= (LB+16)'(stages));
         rsp_tensor_degree <= degree;
         rsp_pipeline_stages <= stages;
      end
   end

   `ASSERT_CLK(a_ready_idle, clock, reset, req_ready |-> st_ff == ST_IDLE)
   `ASSERT_CLK(a_no_req_busy, clock, reset, busy |-> !req_ready)
   `ASSERT_CLK(a_degree_nz, clock, reset, degree != 5'd0 && stages != 5'd0)
endmodule

// File: tb/layer_to_device_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_to_device_mapper_tb
// self-checking bench for the layer to device mapper: an in-bench copy of the
// plan (degree, stage count, layer ranges) predicts every lookup response;
// directed register settings and queries come first, then random phases with
// random idling and back-pressure on both channels
// ----------------------------------------------------------------------------
module layer_to_device_mapper_tb
   import ltdm_pkg::*;
();

   localparam int          NSTAGE       = 16;
   localparam logic [1:0]  CSR_RESERVED = 2'd3;
   localparam int          SETTLE       = 60;
   localparam longint      CYCLE_LIMIT  = 4000000;

   typedef struct packed {
      logic [3:0]  layer_stage;
      logic [3:0]  layer_device;
      logic [3:0]  shard_device;
      logic [19:0] shard_width;
      logic        range_ok;
      logic [15:0] range_first;
      logic [15:0] range_last;
      logic        plan_valid;
      logic [4:0]  tensor_degree;
      logic [4:0]  pipeline_stages;
   } lookup_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_DEVICES;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_layer_index = '0;
   logic [15:0] req_shard_index = '0;
   logic [7:0]  req_stage_query = '0;
   logic [19:0] req_hidden_width = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_layer_stage;
   logic [3:0]  rsp_layer_device;
   logic [3:0]  rsp_shard_device;
   logic [19:0] rsp_shard_width;
   logic        rsp_range_ok;
   logic [15:0] rsp_range_first;
   logic [15:0] rsp_range_last;
   logic        rsp_plan_valid;
   logic [4:0]  rsp_tensor_degree;
   logic [4:0]  rsp_pipeline_stages;

   layer_to_device_mapper dut (.*);

   // plan copy
   logic [7:0]  cfg_devices = 8'd1;
   logic [15:0] cfg_layers  = 16'd0;
   logic [7:0]  cfg_tlimit  = 8'd2;
   int unsigned plan_devcount, plan_degree, plan_stages;
   logic [15:0] plan_first [NSTAGE];
   logic [15:0] plan_last  [NSTAGE];

   lookup_type pending_lookups [$];
   int      error_count = 0;
   bit      req_idle_en = 1'b1;
   bit      rsp_idle_en = 1'b1;
   int      rsp_hold_left = 0;
   longint  cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[layer_to_device_mapper] ERROR");
         $finish;
      end
   end

   function automatic void rebuild_plan_copy();
      int unsigned dc, lim, total, base, rem, cursor, span;
      dc = cfg_devices;
      lim = cfg_tlimit;
      total = cfg_layers;
      if (dc == 0) dc = 1;
      if (dc > DEV_MAX) dc = DEV_MAX;
      if (lim < 1) lim = 1;
      if (lim > 16) lim = 16;
      if (lim > dc) lim = dc;
      plan_degree = 1;
      for (int unsigned d = 1; d <= lim; d++) begin
         if (dc % d == 0) plan_degree = d;
      end
      plan_devcount = dc;
      plan_stages = dc / plan_degree;
      for (int s = 0; s < NSTAGE; s++) begin
         plan_first[s] = '0;
         plan_last[s] = '0;
      end
      if (total != 0) begin
         base = total / plan_stages;
         rem = total % plan_stages;
         cursor = 0;
         for (int unsigned s = 0; s < plan_stages && s < NSTAGE; s++) begin
            span = base + ((s < rem) ? 1 : 0);
            plan_first[s] = cursor[15:0];
            plan_last[s] = (span == 0) ? cursor[15:0] : 16'(cursor + span - 1);
            cursor += span;
         end
      end
   endfunction

   function automatic lookup_type predict_lookup(logic [15:0] layer, logic [15:0] shard,
                                                 logic [7:0] sq, logic [19:0] hidden);
      lookup_type r;
      int unsigned stage, ldev, sdev, top;
      bit found;
      top = (plan_stages > NSTAGE) ? NSTAGE : plan_stages;
      found = 0;
      stage = 0;
      for (int unsigned s = 0; s < top; s++) begin
         if (!found && layer >= plan_first[s] && layer <= plan_last[s]) begin
            stage = s;
            found = 1;
         end
      end
      // past the end goes to the last stage, a gap goes to stage 0
      if (!found) stage = (cfg_layers != 0 && layer >= cfg_layers) ? top - 1 : 0;
      ldev = stage * plan_degree;
      sdev = stage * plan_degree + (shard % plan_degree);
      if (ldev >= plan_devcount) ldev = plan_devcount - 1;
      if (sdev >= plan_devcount) sdev = plan_devcount - 1;
      r.layer_stage = stage[3:0];
      r.layer_device = ldev[3:0];
      r.shard_device = sdev[3:0];
      r.shard_width = (hidden == 0) ? '0 : 20'((hidden + plan_degree - 1) / plan_degree);
      r.range_ok = (sq < plan_stages) && (sq < NSTAGE);
      r.range_first = r.range_ok ? plan_first[sq[3:0]] : '0;
      r.range_last = r.range_ok ? plan_last[sq[3:0]] : '0;
      r.plan_valid = (cfg_layers == 0) || (cfg_layers >= plan_stages);
      r.tensor_degree = plan_degree[4:0];
      r.pipeline_stages = plan_stages[4:0];
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      lookup_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding", $time);
         end else begin
            e = pending_lookups.pop_front();
            check_field("layer_stage", e.layer_stage, rsp_layer_stage);
            check_field("layer_device", e.layer_device, rsp_layer_device);
            check_field("shard_device", e.shard_device, rsp_shard_device);
            check_field("shard_width", e.shard_width, rsp_shard_width);
            check_field("range_ok", e.range_ok, rsp_range_ok);
            check_field("range_first", e.range_first, rsp_range_first);
            check_field("range_last", e.range_last, rsp_range_last);
            check_field("plan_valid", e.plan_valid, rsp_plan_valid);
            check_field("tensor_degree", e.tensor_degree, rsp_tensor_degree);
            check_field("pipeline_stages", e.pipeline_stages, rsp_pipeline_stages);
         end
      end
   end

   // response side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_idle_en || ($urandom_range(99) >= 10);
      end
   end

   task automatic send_lookup(logic [15:0] layer, logic [15:0] shard,
                              logic [7:0] sq, logic [19:0] hidden);
      int gap;
      if (req_idle_en && $urandom_range(99) < 10) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_layer_index <= layer;
      req_shard_index <= shard;
      req_stage_query <= sq;
      req_hidden_width <= hidden;
      do @(posedge clock); while (!req_ready);
      pending_lookups.push_back(predict_lookup(layer, shard, sq, hidden));
   endtask

   task automatic finish_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_lookups();
      finish_requests();
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      drain_lookups();
      csr_valid <= 1'b1;
      csr_index <= idx;
      // upper data bits are random, the block keeps only the register width
      csr_data <= value | ({$urandom} & ((idx == CSR_LAYERS) ? 32'hFFFF0000 : 32'hFFFFFF00));
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEVICES: cfg_devices = value[7:0];
         CSR_LAYERS:  cfg_layers = value[15:0];
         CSR_TLIMIT:  cfg_tlimit = value[7:0];
         default: ;
      endcase
      rebuild_plan_copy();
   endtask

   task automatic set_plan(int unsigned devs, int unsigned layers, int unsigned tlim);
      write_csr(CSR_DEVICES, devs);
      write_csr(CSR_LAYERS, layers);
      write_csr(CSR_TLIMIT, tlim);
   endtask

   task automatic random_lookup();
      logic [15:0] layer;
      logic [7:0]  sq;
      logic [19:0] hidden;
      layer = ($urandom_range(9) < 8) ? 16'($urandom_range(cfg_layers + 3)) : 16'($urandom);
      sq = ($urandom_range(9) < 8) ? 8'($urandom_range(17)) : 8'($urandom);
      hidden = ($urandom_range(3) == 0) ? 20'($urandom_range(40)) : 20'($urandom);
      send_lookup(layer, 16'($urandom), sq, hidden);
   endtask

   task automatic test_reset_plan();
      send_lookup(16'd0, 16'd0, 8'd0, 20'd0);
      send_lookup(16'hFFFF, 16'hFFFF, 8'hFF, 20'hFFFFF);
      send_lookup(16'd7, 16'd1, 8'd1, 20'd1);
   endtask

   task automatic test_directed_plans();
      // twelve devices, limit three: degree 3, four stages, remainder layers
      set_plan(12, 10, 3);
      for (int s = 0; s < 6; s++) send_lookup(16'(s * 2), 16'(s), 8'(s), 20'(s * 7 + 1));
      // fewer layers than stages gives zero-span stages
      set_plan(16, 5, 1);
      for (int s = 0; s < 17; s += 4) send_lookup(16'(s), 16'd3, 8'(s), 20'd2);
      // clamping: zero devices and zero limit, then out-of-range counts
      set_plan(0, 0, 0);
      send_lookup(16'd9, 16'hFFFF, 8'd0, 20'hFFFFF);
      set_plan(255, 65535, 255);
      send_lookup(16'hFFFF, 16'hFFFF, 8'd15, 20'hFFFFF);
      send_lookup(16'd0, 16'd0, 8'd16, 20'd0);
      write_csr(CSR_RESERVED, 32'hFFFFFFFF);
      send_lookup(16'h8000, 16'd5, 8'hFF, 20'h80000);
   endtask

   task automatic test_backpressure();
      set_plan(8, 100, 2);
      rsp_hold_left = 300;
      for (int i = 0; i < 12; i++) random_lookup();
      drain_lookups();
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 20; p++) begin
         write_csr(CSR_DEVICES, ($urandom_range(9) == 0) ? $urandom_range(255) :
                                $urandom_range(0, 17));
         write_csr(CSR_LAYERS, ($urandom_range(9) == 0) ? $urandom_range(3000) :
                               $urandom_range(0, 60));
         write_csr(CSR_TLIMIT, ($urandom_range(9) == 0) ? $urandom_range(255) :
                               $urandom_range(0, 17));
         // some phases run flat out on both sides
         req_idle_en = (p % 5 != 3);
         rsp_idle_en = req_idle_en;
         for (int i = 0; i < 100; i++) random_lookup();
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      rebuild_plan_copy();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_plan();
      test_directed_plans();
      test_backpressure();
      test_random_phases();
      drain_lookups();
      if (error_count == 0) begin
         $display("[layer_to_device_mapper] OK");
      end else begin
         $display("[layer_to_device_mapper] ERROR");
      end
      $finish;
   end

endmodule
